// ===== hdl/ifhg_pkg.sv =====
// shared types and constants for the ipv4 fragment header generator
`default_nettype none
package ifhg_pkg;

  localparam int LEN_W      = 16;
  localparam int PROTO_W    = 8;
  localparam int ADDR_W     = 32;
  localparam int OFF_W      = 13;
  localparam int WORD_W     = 16;
  localparam int TTL_W      = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;
  localparam int BASE_W     = 19;
  localparam int SUM_W      = 20;

  localparam logic [LEN_W-1:0]  MAX_PAYLOAD  = 16'd65515;
  localparam logic [LEN_W-1:0]  MIN_FRAG     = 16'd1024;
  localparam logic [LEN_W-1:0]  HDR_BYTES    = 16'd20;
  localparam logic [LEN_W-1:0]  FRAG_MASK    = 16'hfff8;
  localparam logic [WORD_W-1:0] VER_IHL_TOS  = 16'h4500;
  localparam logic [LEN_W-1:0]  RESET_FRAG   = 16'd1480;
  localparam logic [TTL_W-1:0]  RESET_TTL    = 8'd100;
  localparam logic [WORD_W-1:0] RESET_IDENT  = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAG_PAYLOAD = 1'b0,
    REG_TIME_TO_LIVE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_FRAG,
    ST_CSUM,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic load;
    logic base;
    logic frag;
    logic csum;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ifhg_ctrl.sv =====
// controller state machine sequencing the fragments of one datagram
`default_nettype none
module ifhg_ctrl
  import ifhg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (!rst) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load   = 1'b1;
            state_next = ST_BASE;
          end
        end
      end
      ST_BASE: begin
        cmd.base   = 1'b1;
        state_next = ST_FRAG;
      end
      ST_FRAG: begin
        cmd.frag   = 1'b1;
        state_next = ST_CSUM;
      end
      ST_CSUM: begin
        cmd.csum   = 1'b1;
        state_next = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.more) begin
            cmd.advance = 1'b1;
            state_next  = ST_FRAG;
          end else begin
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/ifhg_dpath.sv =====
// datapath: config registers, datagram fields, fragment arithmetic and checksum
`default_nettype none
module ifhg_dpath
  import ifhg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_data,
  input  wire dp_cmd_t               cmd,
  output dp_stat_t                   stat,
  output logic [OUT_DATA_W-1:0]      out_data,
  output logic                       out_last
);

  logic [LEN_W-1:0]   fragment_payload;
  logic [TTL_W-1:0]   time_to_live;
  logic [WORD_W-1:0]  datagram_ident;

  logic [LEN_W-1:0]   len;
  logic [PROTO_W-1:0] proto;
  logic [ADDR_W-1:0]  src;
  logic [ADDR_W-1:0]  dst;
  logic [TTL_W-1:0]   ttl;
  logic [WORD_W-1:0]  ident;
  logic [LEN_W-1:0]   frag;
  logic [BASE_W-1:0]  base_sum;
  logic [LEN_W-1:0]   done;

  logic               more;
  logic [LEN_W-1:0]   tot;
  logic [OFF_W-1:0]   off;

  logic [LEN_W-1:0]   in_len;
  logic [LEN_W-1:0]   frag_masked;
  logic [LEN_W-1:0]   rest;
  logic               more_next;
  logic [LEN_W-1:0]   piece;
  logic [WORD_W-1:0]  flag_off;
  logic [SUM_W-1:0]   sum;
  logic [WORD_W:0]    fold1;
  logic [WORD_W:0]    fold2;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_payload <= RESET_FRAG;
      time_to_live     <= RESET_TTL;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FRAG_PAYLOAD: fragment_payload <= cfg_wdata[LEN_W-1:0];
        REG_TIME_TO_LIVE: time_to_live     <= cfg_wdata[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      datagram_ident <= RESET_IDENT;
    end else if (cmd.load) begin
      datagram_ident <= datagram_ident + 1'b1;
    end
  end

  assign in_len      = in_data[LEN_W-1:0];
  assign frag_masked = fragment_payload & FRAG_MASK;

  // datagram capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len   <= (in_len > MAX_PAYLOAD) ? MAX_PAYLOAD : in_len;
      proto <= in_data[LEN_W +: PROTO_W];
      src   <= in_data[LEN_W+PROTO_W +: ADDR_W];
      dst   <= in_data[LEN_W+PROTO_W+ADDR_W +: ADDR_W];
      ttl   <= time_to_live;
      ident <= datagram_ident;
      frag  <= (frag_masked < MIN_FRAG) ? MIN_FRAG : frag_masked;
    end
  end

  // header words common to all fragments
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      base_sum <= BASE_W'(VER_IHL_TOS) + BASE_W'(ident) + BASE_W'({ttl, proto})
                + BASE_W'(src[31:16]) + BASE_W'(src[15:0])
                + BASE_W'(dst[31:16]) + BASE_W'(dst[15:0]);
      done     <= '0;
    end else if (cmd.advance) begin
      done     <= done + frag;
    end
  end

  assign rest      = len - done;
  assign more_next = rest > frag;
  assign piece     = more_next ? frag : rest;

  always_ff @(posedge clk) begin
    if (cmd.frag) begin
      more <= more_next;
      tot  <= piece + HDR_BYTES;
      off  <= done[LEN_W-1:3];
    end
  end

  assign flag_off = {2'b00, more, off};
  assign sum      = SUM_W'(base_sum) + SUM_W'(tot) + SUM_W'(flag_off);
  assign fold1    = (WORD_W+1)'(sum[WORD_W-1:0]) + (WORD_W+1)'(sum[SUM_W-1:WORD_W]);
  assign fold2    = (WORD_W+1)'(fold1[WORD_W-1:0]) + (WORD_W+1)'(fold1[WORD_W]);

  // output register
  always_ff @(posedge clk) begin
    if (cmd.csum) begin
      out_data <= {2'b00, ~fold2[WORD_W-1:0], ident, tot, more, off};
      out_last <= ~more;
    end
  end

  assign stat.more = more;

endmodule
`default_nettype wire

// ===== hdl/ipv4_fragment_header_generator_unit.sv =====
// top level of the ipv4 fragment header generator
// Takes one datagram descriptor per transfer and emits one IPv4 fragment header
// per fragment, in order of increasing offset, with tlast on the final one. The
// block handles one datagram at a time: it takes the descriptor, then sums the
// header words common to all fragments, and each fragment then passes through
// a length step, a checksum step and the output transfer, which waits until the
// master side is ready. A datagram has at most 64 fragments. The identification
// starts at 1 after reset and counts up per datagram.
// Configuration: index 0 is the fragment payload size (low three bits ignored,
// at least 1024 used), index 1 is the TTL; write only while idle.
`default_nettype none
module ipv4_fragment_header_generator_unit
  import ifhg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // payload_length[15:0], protocol[23:16], source_addr[55:24], dest_addr[87:56]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // frag_offset[12:0], more_fragments[13], total_length[29:14],
  // identification[45:30], header_checksum[61:46], zero[63:62]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ifhg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  ifhg_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
`default_nettype wire
